// ----- sv/rrop_pkg.sv -----
// shared types and constants for the relay-reply option parser
// no dependencies; used by every module of the block
package rrop_pkg;

   // fixed layout of the relay-reply payload
   localparam int HDR_LEN         = 34;
   localparam int TYPE_RELAY_REPL = 13;
   localparam int CODE_RELAY_MSG  = 9;
   localparam int CODE_IFACE_ID   = 18;
   localparam int PEER_START      = 18;
   localparam int LINK_START      = 2;
   localparam int OUT_NAME        = 16;

   // bytes after this many are ignored, last_byte still ends the payload
   localparam int MAX_PAYLOAD = 65535;

   localparam int NAME_BYTES_DEFAULT = 16;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_HEADER   = 2'd1,
      STATUS_OVERSIZE = 2'd2,
      STATUS_MISSING  = 2'd3
   } status_type;

   // one input beat
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
   } beat_type;

   // one result beat
   typedef struct packed {
      status_type  status;
      logic [15:0] inner_offset;
      logic [15:0] inner_length;
      logic [63:0] peer_high;
      logic [63:0] peer_low;
      logic [63:0] name_high;
      logic [63:0] name_low;
   } result_type;

endpackage

// ----- sv/rrop_in_stage.sv -----
// input register for the relay-reply option parser
// depends on rrop_pkg for the beat type
module rrop_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_payload_byte,
   input  logic               req_last_byte,
   input  logic               advance,
   output logic               held_valid,
   output rrop_pkg::beat_type held_beat
);

   logic               valid_ff;
   rrop_pkg::beat_type beat_ff;
   logic               accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff.payload_byte <= req_payload_byte;
         beat_ff.last_byte    <= req_last_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_beat  = beat_ff;

endmodule

// ----- sv/rrop_parser.sv -----
// per-byte parse state and result computation of the relay-reply parser
// depends on rrop_pkg for layout constants, beat and result types
module rrop_parser #(
   parameter int NAME_BYTES = rrop_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  rrop_pkg::beat_type   beat,
   output rrop_pkg::result_type result
);

   // only the first bytes of the name ever reach the result
   localparam int NAME_STORE = (NAME_BYTES < rrop_pkg::OUT_NAME) ?
                               NAME_BYTES : rrop_pkg::OUT_NAME;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_OPTHDR = 3'd1,
      PH_PEND   = 3'd2,
      PH_DATA   = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   logic [15:0] pos_ff,   pos_in,   nx_pos;
   phase_type   phase_ff, phase_in, nx_phase;
   logic        bad_ff,   bad_in,   nx_bad;
   logic [63:0] peer_ff   [2];
   logic [63:0] peer_in   [2];
   logic [63:0] nx_peer   [2];
   logic [7:0]  name_ff   [NAME_STORE];
   logic [7:0]  name_in   [NAME_STORE];
   logic [7:0]  nx_name   [NAME_STORE];
   logic [15:0] code_ff,  code_in,  nx_code;
   logic [15:0] len_ff,   len_in,   nx_len;
   logic [15:0] left_ff,  left_in,  nx_left;
   logic [15:0] roff_ff,  roff_in,  nx_roff;
   logic [15:0] rlen_ff,  rlen_in,  nx_rlen;
   logic        stop_ff,  stop_in,  nx_stop;
   logic        over_ff,  over_in,  nx_over;
   logic [1:0]  hcnt_ff,  hcnt_in,  nx_hcnt;
   logic        finish;

   assign finish = take && beat.last_byte;

   // state after this byte, before the end-of-payload return to reset
   always_comb begin
      logic [7:0]  b;
      logic [15:0] idx;
      logic [3:0]  k;
      nx_pos   = pos_ff;
      nx_phase = phase_ff;
      nx_bad   = bad_ff;
      nx_peer  = peer_ff;
      nx_name  = name_ff;
      nx_code  = code_ff;
      nx_len   = len_ff;
      nx_left  = left_ff;
      nx_roff  = roff_ff;
      nx_rlen  = rlen_ff;
      nx_stop  = stop_ff;
      nx_over  = over_ff;
      nx_hcnt  = hcnt_ff;
      b   = beat.payload_byte;
      idx = len_ff - left_ff;
      k   = 4'(pos_ff - 16'(rrop_pkg::PEER_START));
      if (take && (pos_ff < 16'(rrop_pkg::MAX_PAYLOAD))) begin
         if (phase_ff == PH_HEADER) begin
            if (pos_ff == 16'd0) begin
               if (b != 8'(rrop_pkg::TYPE_RELAY_REPL)) nx_bad = 1'b1;
            end else if (pos_ff >= 16'(rrop_pkg::LINK_START) &&
                         pos_ff < 16'(rrop_pkg::PEER_START)) begin
               if (b != 8'd0) nx_bad = 1'b1;
            end else if (pos_ff >= 16'(rrop_pkg::PEER_START) &&
                         pos_ff < 16'(rrop_pkg::HDR_LEN)) begin
               nx_peer[k[3]] = {peer_ff[k[3]][55:0], b};
            end
            if (pos_ff == 16'(rrop_pkg::HDR_LEN - 1)) begin
               nx_phase = PH_OPTHDR;
               nx_hcnt  = 2'd0;
            end
         end else if (phase_ff != PH_STOP) begin
            // option header complete: commit it on the first byte after
            if (nx_phase == PH_PEND) begin
               if (code_ff == 16'd0) begin
                  nx_stop  = 1'b1;
                  nx_phase = PH_STOP;
               end else if (code_ff == 16'(rrop_pkg::CODE_IFACE_ID) &&
                            len_ff > 16'(NAME_BYTES)) begin
                  nx_over  = 1'b1;
                  nx_stop  = 1'b1;
                  nx_phase = PH_STOP;
               end else begin
                  if (code_ff == 16'(rrop_pkg::CODE_IFACE_ID)) begin
                     for (int i = 0; i < NAME_STORE; i++) nx_name[i] = 8'd0;
                  end else if (code_ff == 16'(rrop_pkg::CODE_RELAY_MSG)) begin
                     nx_roff = pos_ff;
                     nx_rlen = len_ff;
                  end
                  nx_left = len_ff;
                  idx     = 16'd0;
                  if (len_ff == 16'd0) begin
                     nx_phase = PH_OPTHDR;
                     nx_hcnt  = 2'd0;
                  end else begin
                     nx_phase = PH_DATA;
                  end
               end
            end
            if (nx_phase == PH_DATA) begin
               if (nx_code == 16'(rrop_pkg::CODE_IFACE_ID)) begin
                  for (int i = 0; i < NAME_STORE; i++) begin
                     if (idx == 16'(i)) nx_name[i] = b;
                  end
               end
               nx_left = nx_left - 16'd1;
               if (nx_left == 16'd0) begin
                  nx_phase = PH_OPTHDR;
                  nx_hcnt  = 2'd0;
               end
            end else if (nx_phase == PH_OPTHDR) begin
               unique case (nx_hcnt)
                  2'd0: nx_code = {b, 8'h00};
                  2'd1: nx_code = nx_code | {8'h00, b};
                  2'd2: nx_len  = {b, 8'h00};
                  2'd3: nx_len  = nx_len | {8'h00, b};
                  default: nx_len = nx_len;
               endcase
               nx_hcnt = nx_hcnt + 2'd1;
               if (nx_hcnt == 2'd0) nx_phase = PH_PEND;
            end
         end
         nx_pos = pos_ff + 16'd1;
      end
   end

   // result from the updated state
   always_comb begin
      logic [7:0]  pad [rrop_pkg::OUT_NAME];
      logic [15:0] rest;
      rrop_pkg::status_type st;
      for (int i = 0; i < rrop_pkg::OUT_NAME; i++) pad[i] = 8'd0;
      for (int i = 0; i < NAME_STORE; i++) pad[i] = nx_name[i];
      rest = nx_pos - nx_roff;
      if (nx_bad || nx_pos < 16'(rrop_pkg::HDR_LEN)) begin
         st = rrop_pkg::STATUS_HEADER;
      end else if (nx_over) begin
         st = rrop_pkg::STATUS_OVERSIZE;
      end else if (nx_roff == 16'd0 || pad[0] == 8'd0) begin
         st = rrop_pkg::STATUS_MISSING;
      end else begin
         st = rrop_pkg::STATUS_OK;
      end
      result = '0;
      result.status = st;
      if (st == rrop_pkg::STATUS_OK) begin
         result.inner_offset = nx_roff;
         result.inner_length = (nx_rlen < rest) ? nx_rlen : rest;
         result.peer_high    = nx_peer[0];
         result.peer_low     = nx_peer[1];
         for (int i = 0; i < 8; i++) begin
            result.name_high[63 - 8*i -: 8] = pad[i];
            result.name_low[63 - 8*i -: 8]  = pad[i + 8];
         end
      end
   end

   // end of payload puts everything back to the reset state
   always_comb begin
      if (finish) begin
         pos_in   = 16'd0;
         phase_in = PH_HEADER;
         bad_in   = 1'b0;
         peer_in  = '{64'd0, 64'd0};
         for (int i = 0; i < NAME_STORE; i++) name_in[i] = 8'd0;
         code_in  = 16'd0;
         len_in   = 16'd0;
         left_in  = 16'd0;
         roff_in  = 16'd0;
         rlen_in  = 16'd0;
         stop_in  = 1'b0;
         over_in  = 1'b0;
         hcnt_in  = 2'd0;
      end else begin
         pos_in   = nx_pos;
         phase_in = nx_phase;
         bad_in   = nx_bad;
         peer_in  = nx_peer;
         name_in  = nx_name;
         code_in  = nx_code;
         len_in   = nx_len;
         left_in  = nx_left;
         roff_in  = nx_roff;
         rlen_in  = nx_rlen;
         stop_in  = nx_stop;
         over_in  = nx_over;
         hcnt_in  = nx_hcnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 16'd0;
         phase_ff <= PH_HEADER;
         bad_ff   <= 1'b0;
         peer_ff  <= '{64'd0, 64'd0};
         for (int i = 0; i < NAME_STORE; i++) name_ff[i] <= 8'd0;
         code_ff  <= 16'd0;
         len_ff   <= 16'd0;
         left_ff  <= 16'd0;
         roff_ff  <= 16'd0;
         rlen_ff  <= 16'd0;
         stop_ff  <= 1'b0;
         over_ff  <= 1'b0;
         hcnt_ff  <= 2'd0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         bad_ff   <= bad_in;
         peer_ff  <= peer_in;
         name_ff  <= name_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         roff_ff  <= roff_in;
         rlen_ff  <= rlen_in;
         stop_ff  <= stop_in;
         over_ff  <= over_in;
         hcnt_ff  <= hcnt_in;
      end
   end

endmodule

// ----- sv/rrop_out_stage.sv -----
// result register of the relay-reply option parser
// depends on rrop_pkg for the result type
module rrop_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rrop_pkg::result_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rrop_pkg::result_type held
);

   logic                 valid_ff;
   rrop_pkg::result_type result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = result_ff;

endmodule

// ----- sv/relay_reply_option_parser.sv -----
// top level of the relay-reply option parser
// depends on rrop_pkg, rrop_in_stage, rrop_parser and rrop_out_stage
//
// usage
//   req channel: one payload byte per beat, req_last_byte on the final byte.
//   rsp channel: one result beat per payload, issued for its last byte:
//     status, inner_offset/inner_length, peer address, interface name.
//   both channels: a beat moves when valid is high and stall is low.
// path: a last byte's beat is held in the input register, then parsed into
//   the result register, which drives rsp.
// throughput: one byte per cycle while no last byte waits on a stalled rsp,
//   set by the per-byte state update between the input and result registers.
// stall: while rsp is stalled with a result held, bytes that are not last
//   keep flowing; a last byte waits in the input register and req_stall
//   goes high until the held result is taken.
// reset: synchronous; clears both stage valids and returns the parser to
//   its header phase with all capture state zero. the parser also returns
//   to that state after every last byte.
module relay_reply_option_parser #(
   parameter int NAME_BYTES = rrop_pkg::NAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_inner_offset,
   output logic [15:0] rsp_inner_length,
   output logic [63:0] rsp_peer_high,
   output logic [63:0] rsp_peer_low,
   output logic [63:0] rsp_name_high,
   output logic [63:0] rsp_name_low
);

   logic                 held_valid;
   rrop_pkg::beat_type   held_beat;
   logic                 advance;
   logic                 out_free;
   rrop_pkg::result_type result;
   rrop_pkg::result_type rsp_held;

   // result register can take a new beat this cycle
   assign out_free = !rsp_valid || !rsp_stall;
   // a byte that ends the payload needs room for its result
   assign advance  = held_valid && (!held_beat.last_byte || out_free);

   rrop_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .advance          (advance),
      .held_valid       (held_valid),
      .held_beat        (held_beat)
   );

   rrop_parser #(
      .NAME_BYTES (NAME_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .take   (advance),
      .beat   (held_beat),
      .result (result)
   );

   rrop_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && held_beat.last_byte),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .held      (rsp_held)
   );

   assign rsp_status       = rsp_held.status;
   assign rsp_inner_offset = rsp_held.inner_offset;
   assign rsp_inner_length = rsp_held.inner_length;
   assign rsp_peer_high    = rsp_held.peer_high;
   assign rsp_peer_low     = rsp_held.peer_low;
   assign rsp_name_high    = rsp_held.name_high;
   assign rsp_name_low     = rsp_held.name_low;

endmodule
